[rtl/core/dfnv_pkg.sv]
// Shared constants and hash arithmetic for the dual FNV hash block.
`timescale 1ns / 1ps

package dfnv_pkg;

  localparam int BYTE_W = 8;
  localparam int HASH_W = 64;
  localparam int HALF_W = 32;
  localparam int PAIR_W = 3;

  // Mode codes for the width selection register.
  localparam logic MODE_NARROW = 1'b0;
  localparam logic MODE_WIDE   = 1'b1;

  localparam logic [HALF_W-1:0] BASIS32 = 32'h811c_9dc5;
  localparam logic [HASH_W-1:0] BASIS64 = 64'hcbf2_9ce4_8422_2325;

  // Index of the last byte pair of a digest in each mode.
  localparam logic [PAIR_W-1:0] LAST_PAIR_NARROW = 3'd3;
  localparam logic [PAIR_W-1:0] LAST_PAIR_WIDE   = 3'd7;

  // Offset basis of the selected width, zero-extended in narrow mode.
  function automatic logic [HASH_W-1:0] basis_of(input logic wide);
    logic [HASH_W-1:0] res;
    res = (wide == MODE_WIDE) ? BASIS64 : {{(HASH_W-HALF_W){1'b0}}, BASIS32};
    return res;
  endfunction

  // Multiply by the 32-bit prime 0x01000193 as a sum of shifted copies.
  function automatic logic [HALF_W-1:0] mul_prime32(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] res;
    res = (v << 24) + (v << 8) + (v << 7) + (v << 4) + (v << 1) + v;
    return res;
  endfunction

  // Multiply by the 64-bit prime 0x00000100000001B3 as a sum of shifted copies.
  function automatic logic [HASH_W-1:0] mul_prime64(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] res;
    res = (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 1) + v;
    return res;
  endfunction

  // Width-selected prime multiply; the upper half stays zero in narrow mode.
  function automatic logic [HASH_W-1:0] mul_prime(input logic wide,
                                                  input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] res;
    if (wide == MODE_WIDE) begin
      res = mul_prime64(v);
    end else begin
      res = {{(HASH_W-HALF_W){1'b0}}, mul_prime32(v[HALF_W-1:0])};
    end
    return res;
  endfunction

endpackage

[rtl/core/dfnv_ifs.sv]
// Valid/ready channel interfaces for message bytes and digest bytes.
`timescale 1ns / 1ps

interface dfnv_in_if;
  import dfnv_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface dfnv_out_if;
  import dfnv_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] digest_byte;
  logic              digest_last;

  modport source (output valid, output digest_byte, output digest_last, input ready);
  modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

[rtl/core/dual_fnv_hash_key_top.sv]
// Top level of the dual FNV-1 / FNV-1a byte-serial hash block.
`timescale 1ns / 1ps

// Usage notes.
// Message bytes enter on in_item, one byte per item, with end_of_message set on
// the final byte. Both hashes are updated in the same cycle that a byte is
// accepted, so an ordinary byte is taken every cycle with no result.
// When the final byte is accepted, the updated hashes are copied into a digest
// buffer and both running hashes reload the offset basis. The digest leaves on
// out_item starting the next cycle: 8 items in narrow mode, 16 in wide mode,
// FNV-1 byte then FNV-1a byte of the same weight, most significant first, with
// digest_last set on the final one. It drains at one item per cycle while the
// receiver keeps ready high; the rate is set by the receiver's ready.
// Ordinary bytes of the next message are still accepted while a digest drains.
// A final byte is held off until the buffer is free, which is at the latest in
// the cycle that takes the last digest item, so a stalled receiver stalls the
// sender only at message ends.
// cfg_wr_en writes wide_mode (0 = 32-bit, 1 = 64-bit) and reloads both hashes;
// write only while the block is idle. Reset selects 32-bit mode, loads the
// 32-bit offset basis and empties the digest buffer.

module dual_fnv_hash_key_top
  import dfnv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  dfnv_in_if.sink           in_item,
  dfnv_out_if.source        out_item
);

  logic              wide_r, wide_nxt;
  logic [HASH_W-1:0] fnv1_r, fnv1_nxt;
  logic [HASH_W-1:0] fnv1a_r, fnv1a_nxt;
  logic [HASH_W-1:0] dig1_r, dig1_nxt;
  logic [HASH_W-1:0] dig1a_r, dig1a_nxt;
  logic              half_r, half_nxt;
  logic [PAIR_W-1:0] pairs_r, pairs_nxt;
  logic              busy_r, busy_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              out_end;
  logic              take_last;
  logic [HASH_W-1:0] byte_ext;
  logic [HASH_W-1:0] fnv1_step;
  logic [HASH_W-1:0] fnv1a_step;

  assign byte_ext   = {{(HASH_W-BYTE_W){1'b0}}, in_item.data_byte};
  assign fnv1_step  = mul_prime(wide_r, fnv1_r) ^ byte_ext;
  assign fnv1a_step = mul_prime(wide_r, fnv1a_r ^ byte_ext);

  assign out_fire  = out_item.valid && out_item.ready;
  assign out_end   = out_fire && out_item.digest_last;
  // A final byte needs the digest buffer; ordinary bytes never wait.
  assign in_item.ready = !(busy_r && !out_end && in_item.end_of_message);
  assign in_fire   = in_item.valid && in_item.ready;
  assign take_last = in_fire && in_item.end_of_message;

  assign out_item.valid       = busy_r;
  assign out_item.digest_byte = half_r ? dig1a_r[HASH_W-1 -: BYTE_W]
                                       : dig1_r[HASH_W-1 -: BYTE_W];
  assign out_item.digest_last = half_r && (pairs_r == '0);

  // Running hashes and mode register.
  always_comb begin
    wide_nxt  = wide_r;
    fnv1_nxt  = fnv1_r;
    fnv1a_nxt = fnv1a_r;
    if (cfg_wr_en) begin
      wide_nxt  = cfg_wr_data;
      fnv1_nxt  = basis_of(cfg_wr_data);
      fnv1a_nxt = basis_of(cfg_wr_data);
    end else if (take_last) begin
      fnv1_nxt  = basis_of(wide_r);
      fnv1a_nxt = basis_of(wide_r);
    end else if (in_fire) begin
      fnv1_nxt  = fnv1_step;
      fnv1a_nxt = fnv1a_step;
    end
  end

  // Digest buffer: values are left-aligned so the top byte is always next.
  always_comb begin
    dig1_nxt  = dig1_r;
    dig1a_nxt = dig1a_r;
    half_nxt  = half_r;
    pairs_nxt = pairs_r;
    busy_nxt  = busy_r;
    if (out_fire) begin
      if (!half_r) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt  = 1'b0;
        dig1_nxt  = dig1_r << BYTE_W;
        dig1a_nxt = dig1a_r << BYTE_W;
        pairs_nxt = pairs_r - 1'b1;
        if (pairs_r == '0) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (take_last) begin
      busy_nxt = 1'b1;
      half_nxt = 1'b0;
      if (wide_r == MODE_WIDE) begin
        dig1_nxt  = fnv1_step;
        dig1a_nxt = fnv1a_step;
        pairs_nxt = LAST_PAIR_WIDE;
      end else begin
        dig1_nxt  = {fnv1_step[HALF_W-1:0], {HALF_W{1'b0}}};
        dig1a_nxt = {fnv1a_step[HALF_W-1:0], {HALF_W{1'b0}}};
        pairs_nxt = LAST_PAIR_NARROW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= MODE_NARROW;
      fnv1_r  <= basis_of(MODE_NARROW);
      fnv1a_r <= basis_of(MODE_NARROW);
      half_r  <= 1'b0;
      pairs_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      wide_r  <= wide_nxt;
      fnv1_r  <= fnv1_nxt;
      fnv1a_r <= fnv1a_nxt;
      half_r  <= half_nxt;
      pairs_r <= pairs_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig1_r  <= dig1_nxt;
    dig1a_r <= dig1a_nxt;
  end

  // A final byte is only captured when the buffer is free or just emptying.
  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |-> (!busy_r || out_end))
    else $error("digest captured over an undelivered digest");

  // Every captured digest is offered on the next cycle.
  a_capture_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> (out_item.valid && !half_r))
    else $error("captured digest not offered");

  // The buffer empties after its final item unless a new digest arrives.
  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_end && !take_last) |=> !out_item.valid)
    else $error("digest buffer still busy after its final item");

  // In narrow mode the upper halves of both hashes stay zero.
  a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (wide_r == MODE_NARROW) |-> (fnv1_r[HASH_W-1:HALF_W] == '0 &&
                                 fnv1a_r[HASH_W-1:HALF_W] == '0))
    else $error("upper hash bits set in narrow mode");

  // A mode write reloads both hashes with the new basis.
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (fnv1_r == basis_of(wide_r) && fnv1a_r == basis_of(wide_r)))
    else $error("hashes not reloaded after a mode write");

endmodule

[verif/dfnv_digest_checker.sv]
// Watches both channels, predicts the dual FNV digest bytes and compares them.
`timescale 1ns / 1ps

module dfnv_digest_checker
  import dfnv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  dfnv_in_if   msg_ch,
  dfnv_out_if  dig_ch,
  output int   fail_count,
  output int   outstanding
);

  localparam logic [HALF_W-1:0] FNV_PRIME32 = 32'h0100_0193;
  localparam logic [HASH_W-1:0] FNV_PRIME64 = 64'h0000_0100_0000_01b3;

  typedef struct packed {
    logic [BYTE_W-1:0] digest_byte;
    logic              digest_last;
  } digest_item_t;

  logic              wide_mode;
  logic [HASH_W-1:0] fnv1_acc;
  logic [HASH_W-1:0] fnv1a_acc;
  digest_item_t      digest_q[$];
  int                errors;

  // Prime multiply at the selected width; narrow mode keeps the upper half at zero.
  function automatic logic [HASH_W-1:0] times_prime(input logic wide,
                                                    input logic [HASH_W-1:0] v);
    logic [HALF_W-1:0] narrow;
    if (wide == MODE_WIDE) begin
      return v * FNV_PRIME64;
    end
    narrow = v[HALF_W-1:0] * FNV_PRIME32;
    return {{(HASH_W-HALF_W){1'b0}}, narrow};
  endfunction

  task automatic restart_hashes();
    fnv1_acc  = (wide_mode == MODE_WIDE) ? BASIS64 : {{(HASH_W-HALF_W){1'b0}}, BASIS32};
    fnv1a_acc = fnv1_acc;
  endtask

  // Both hashes absorb the byte; a final byte queues the interleaved digest.
  task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic eom);
    int nbytes;
    int shift;
    fnv1_acc  = times_prime(wide_mode, fnv1_acc) ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    fnv1a_acc = times_prime(wide_mode, fnv1a_acc ^ {{(HASH_W-BYTE_W){1'b0}}, b});
    if (eom) begin
      nbytes = (wide_mode == MODE_WIDE) ? 8 : 4;
      for (int k = 0; k < nbytes; k++) begin
        shift = (nbytes - 1 - k) * 8;
        digest_q.push_back(digest_item_t'{BYTE_W'(fnv1_acc >> shift), 1'b0});
        digest_q.push_back(digest_item_t'{BYTE_W'(fnv1a_acc >> shift), k == nbytes - 1});
      end
      restart_hashes();
    end
  endtask

  always @(posedge clk) begin : watch
    digest_item_t want;
    if (!rst_n) begin
      wide_mode = MODE_NARROW;
      restart_hashes();
      digest_q.delete();
      errors = 0;
    end else begin
      // Results leave first so that a digest queued at this edge is never matched early.
      if (dig_ch.valid && dig_ch.ready) begin
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected digest item, expected none, actual byte 0x%02h last %0b",
                   $time, dig_ch.digest_byte, dig_ch.digest_last);
        end else begin
          want = digest_q.pop_front();
          if (dig_ch.digest_byte !== want.digest_byte) begin
            errors++;
            $display("%0t: digest_byte mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want.digest_byte, dig_ch.digest_byte);
          end
          if (dig_ch.digest_last !== want.digest_last) begin
            errors++;
            $display("%0t: digest_last mismatch, expected %0b, actual %0b",
                     $time, want.digest_last, dig_ch.digest_last);
          end
        end
      end
      if (cfg_wr_en) begin
        wide_mode = cfg_wr_data;
        restart_hashes();
      end
      if (msg_ch.valid && msg_ch.ready) begin
        absorb_byte(msg_ch.data_byte, msg_ch.end_of_message);
      end
    end
    fail_count  <= errors;
    outstanding <= digest_q.size();
  end

endmodule

[verif/dual_fnv_hash_key_top_tb.sv]
// Top of the dual FNV hash testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module dual_fnv_hash_key_top_tb;
  import dfnv_pkg::*;

  // A byte without end_of_message yields nothing, but the hashes update in the
  // accepting cycle; the settle cycles cover that before any mode write.
  localparam int SETTLE_CYCLES   = 4;
  // Long enough for the single digest buffer to fill and stall the next final byte.
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PHASE_ITEMS     = 62;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asked;
  int hold_served;
  int items_sent;
  int fail_count;
  int outstanding;

  dfnv_in_if  msg_ch();
  dfnv_out_if dig_ch();

  dual_fnv_hash_key_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (msg_ch),
    .out_item    (dig_ch)
  );

  dfnv_digest_checker digest_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg_ch      (msg_ch),
    .dig_ch      (dig_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The whole run is far shorter than this; hitting it means the block hung.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Digest receiver. Each cycle it either honors a pending hold-off request,
  // keeping ready low for the hold-off stretch, or drops ready at the current rate.
  initial begin
    dig_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked > hold_served) begin
        dig_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_served++;
      end else begin
        dig_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one message byte, possibly after some idle cycles, and returns at
  // the edge where the block accepts it. Valid stays high for the next item.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= b;
    msg_ch.end_of_message <= eom;
    do @(posedge clk); while (!msg_ch.ready);
    items_sent++;
  endtask

  // Stops offering bytes and waits until every predicted digest item is out.
  // The first edge lets the checker see a final byte accepted at this edge.
  task automatic drain();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every mode write reloads both hashes, so it is only done with the block idle.
  task automatic set_mode(input logic mode);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly short messages, now and then a longer one; extreme byte values are
  // favored so that every bit is seen both ways.
  task automatic send_random_message();
    int          len;
    logic [BYTE_W-1:0] b;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = BYTE_W'($urandom);
      endcase
      push_byte(b, k == len - 1);
    end
  endtask

  // One random phase at a given mode and idling mix. With squeeze set, the
  // receiver holds off while single-byte messages pile up behind the buffer.
  // The phase ends on an unfinished message, which the next mode write drops.
  task automatic run_phase(input logic mode, input int s_pct, input int r_pct,
                           input bit squeeze);
    int target;
    set_mode(mode);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (squeeze) begin
      hold_asked++;
      repeat (12) push_byte(BYTE_W'($urandom), 1'b1);
    end
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      send_random_message();
    end
    repeat ($urandom_range(3, 1)) push_byte(BYTE_W'($urandom), 1'b0);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= MODE_NARROW;
    msg_ch.valid          <= 1'b0;
    msg_ch.data_byte      <= '0;
    msg_ch.end_of_message <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked    = 0;
    hold_served   = 0;
    items_sent    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the narrow mode that reset selects.
    // Single-byte messages at both byte extremes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Bytes with the top bit set must hash as unsigned values.
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b1);
    // An unfinished message is abandoned when the mode changes to wide.
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    set_mode(MODE_WIDE);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b1);
    // Rewriting the same mode still reloads the hashes and drops the partial message.
    push_byte(8'h12, 1'b0);
    set_mode(MODE_WIDE);
    push_byte(8'hFE, 1'b1);

    // Random part: receiver-heavy idling, then sender-heavy, then none at all.
    run_phase(MODE_NARROW, 22, 64, 1'b0);
    run_phase(MODE_WIDE, 64, 22, 1'b0);
    run_phase(1'($urandom_range(1)), 0, 0, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
